// ===== hw/rtl/gir_pkg.sv =====
// Package for the GF(2) incremental row reducer.
// Holds widths, mode and sweep codes, the command and status structs, and two helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gir_pkg;

  localparam int VEC_W = 64;
  localparam int CNT_W = 7;
  localparam int IDX_W = 6;

  localparam logic [1:0] MODE_ROW     = 2'd0;
  localparam logic [1:0] MODE_COL     = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  typedef enum logic [1:0] {
    OP_ELIM = 2'd0,
    OP_COL  = 2'd1,
    OP_CLR  = 2'd2,
    OP_LOAD = 2'd3
  } op_t;

  typedef struct packed {
    logic             load;
    logic             restart;
    logic             rd_en;
    op_t              op;
    logic [CNT_W-1:0] addr;
    logic             scan_en;
    logic [2:0]       chunk;
    logic             wnew;
    logic             col_inc;
    logic             commit;
    logic             finish;
    logic             reject;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] row_count;
    logic [CNT_W-1:0] col_count;
    logic             found;
    logic [CNT_W-1:0] piv_row;
  } stat_t;

  function automatic logic [VEC_W-1:0] low_mask(input logic [CNT_W-1:0] n);
    logic [VEC_W-1:0] m;
    if (n >= CNT_W'(VEC_W)) m = '1;
    else m = (VEC_W'(1) << n) - VEC_W'(1);
    return m;
  endfunction

  function automatic logic [2:0] low_bit8(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (v[k]) r = 3'(k);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/gir_ctrl.sv =====
// Controller of the row reducer: sequences sweeps, the pivot scan and the result.
// Depends on gir_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gir_ctrl #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  input  wire  [1:0]             mode,
  input  wire  [6:0]             start_cols,
  input  gir_pkg::stat_t         stat,
  output gir_pkg::cmd_t          cmd,
  output logic                   busy
);
  import gir_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ELIM  = 9'b000000010,
    S_SCAN  = 9'b000000100,
    S_WNEW  = 9'b000001000,
    S_COL   = 9'b000010000,
    S_LOADP = 9'b000100000,
    S_LOADW = 9'b001000000,
    S_CLR   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic             pend;
  logic             rej, rej_next;
  logic             sweep_end;

  assign busy      = (state != S_IDLE);
  assign sweep_end = (idx >= stat.row_count) && !pend;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    rej_next   = rej;
    cmd        = '0;
    cmd.op     = OP_ELIM;
    cmd.addr   = idx;
    cmd.chunk  = idx[2:0];
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          idx_next = '0;
          rej_next = 1'b0;
          unique case (mode)
            MODE_ROW: begin
              if (stat.row_count >= CNT_W'(MAX_ROWS)) begin
                rej_next   = 1'b1;
                state_next = S_FIN;
              end else begin
                state_next = S_ELIM;
              end
            end
            MODE_COL: begin
              if (stat.col_count >= CNT_W'(MAX_COLS)) begin
                rej_next   = 1'b1;
                state_next = S_FIN;
              end else begin
                state_next = S_COL;
              end
            end
            MODE_RESTART: begin
              if (start_cols > CNT_W'(MAX_COLS)) rej_next = 1'b1;
              else cmd.restart = 1'b1;
              state_next = S_FIN;
            end
            default: begin
              rej_next   = 1'b1;
              state_next = S_FIN;
            end
          endcase
        end
      end
      S_ELIM: begin
        cmd.op = OP_ELIM;
        if (idx < stat.row_count) begin
          cmd.rd_en = 1'b1;
          idx_next  = idx + 1'b1;
        end else if (sweep_end) begin
          idx_next   = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        idx_next    = idx + 1'b1;
        if (idx[2:0] == 3'd7) state_next = S_WNEW;
      end
      S_WNEW: begin
        cmd.wnew = 1'b1;
        idx_next = '0;
        if (stat.found) begin
          cmd.commit = 1'b1;
          state_next = S_CLR;
        end else begin
          state_next = S_FIN;
        end
      end
      S_COL: begin
        cmd.op = OP_COL;
        if (idx < stat.row_count) begin
          cmd.rd_en = 1'b1;
          idx_next  = idx + 1'b1;
        end else if (sweep_end) begin
          cmd.col_inc = 1'b1;
          state_next  = stat.found ? S_LOADP : S_FIN;
        end
      end
      S_LOADP: begin
        cmd.op     = OP_LOAD;
        cmd.rd_en  = 1'b1;
        cmd.addr   = stat.piv_row;
        cmd.commit = 1'b1;
        state_next = S_LOADW;
      end
      S_LOADW: begin
        idx_next   = '0;
        state_next = S_CLR;
      end
      S_CLR: begin
        cmd.op = OP_CLR;
        if (idx < stat.row_count) begin
          cmd.rd_en = 1'b1;
          idx_next  = idx + 1'b1;
        end else if (sweep_end) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        cmd.reject = rej;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      pend  <= 1'b0;
      rej   <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      pend  <= cmd.rd_en;
      rej   <= rej_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/gir_datapath.sv =====
// Datapath of the row reducer: row stores, pivot masks, accumulators and result.
// Depends on gir_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gir_datapath #(
  parameter int MAX_ROWS = 64
) (
  input  wire                    clk,
  input  wire                    rst,
  input  gir_pkg::cmd_t          cmd,
  input  wire  [1:0]             mode,
  input  wire  [63:0]            row_bits,
  input  wire  [63:0]            column_bits,
  input  wire  [6:0]             start_cols,
  output gir_pkg::stat_t         stat,
  output logic                   done,
  output logic [6:0]             rank,
  output logic                   pivot_found,
  output logic [5:0]             pivot_index,
  output logic                   rejected
);
  import gir_pkg::*;

  localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [VEC_W-1:0] red_mem [MAX_ROWS];
  logic [VEC_W-1:0] ops_mem [MAX_ROWS];
  logic [IDX_W-1:0] rpc_mem [MAX_ROWS];

  logic [VEC_W-1:0] rd_red, rd_ops;
  logic [IDX_W-1:0] rd_rpc;
  logic             s1_v;
  op_t              s1_op;
  logic [CNT_W-1:0] s1_idx;

  logic [1:0]       mode_q;
  logic [VEC_W-1:0] orig, vec, acc_row, acc_ops, cwp, rwp;
  logic [CNT_W-1:0] row_count, col_count, pivot_count, piv_row;
  logic [IDX_W-1:0] piv_col;
  logic             found;

  logic             we;
  logic [ROW_AW-1:0] waddr;
  logic [VEC_W-1:0] wred, wops;
  logic [VEC_W-1:0] cbit, row_in, cand;
  logic [7:0]       chunk_bits;
  logic             par;

  assign stat.row_count = row_count;
  assign stat.col_count = col_count;
  assign stat.found     = found;
  assign stat.piv_row   = piv_row;

  assign cbit       = VEC_W'(1) << col_count;
  assign row_in     = row_bits & low_mask(col_count);
  assign cand       = acc_row & ~cwp;
  assign chunk_bits = cand[cmd.chunk*8 +: 8];
  assign par        = ^(rd_ops & vec);

  always_comb begin
    we    = 1'b0;
    waddr = s1_idx[ROW_AW-1:0];
    wred  = rd_red;
    wops  = rd_ops;
    if (cmd.wnew) begin
      we    = 1'b1;
      waddr = row_count[ROW_AW-1:0];
      wred  = acc_row;
      wops  = acc_ops;
    end else if (s1_v) begin
      case (s1_op)
        OP_COL: begin
          if (par) begin
            we   = 1'b1;
            wred = rd_red | cbit;
          end
        end
        OP_CLR: begin
          if (s1_idx != piv_row && rd_red[piv_col]) begin
            we   = 1'b1;
            wred = rd_red ^ acc_row;
            wops = rd_ops ^ acc_ops;
          end
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      red_mem[waddr] <= wred;
      ops_mem[waddr] <= wops;
    end
    if (cmd.commit) rpc_mem[piv_row[ROW_AW-1:0]] <= piv_col;
    if (cmd.rd_en) begin
      rd_red <= red_mem[cmd.addr[ROW_AW-1:0]];
      rd_ops <= ops_mem[cmd.addr[ROW_AW-1:0]];
      rd_rpc <= rpc_mem[cmd.addr[ROW_AW-1:0]];
    end
    s1_op  <= cmd.op;
    s1_idx <= cmd.addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v        <= 1'b0;
      row_count   <= '0;
      col_count   <= '0;
      pivot_count <= '0;
      cwp         <= '0;
      rwp         <= '0;
      found       <= 1'b0;
      done        <= 1'b0;
    end else begin
      s1_v <= cmd.rd_en;
      done <= cmd.finish;
      if (cmd.load) begin
        mode_q  <= mode;
        orig    <= row_in;
        acc_row <= row_in;
        acc_ops <= VEC_W'(1) << row_count;
        vec     <= column_bits & low_mask(row_count);
        found   <= 1'b0;
        piv_row <= row_count;
        piv_col <= col_count[IDX_W-1:0];
      end
      if (cmd.restart) begin
        row_count   <= '0;
        col_count   <= start_cols;
        pivot_count <= '0;
        cwp         <= '0;
        rwp         <= '0;
      end
      if (s1_v) begin
        case (s1_op)
          OP_ELIM: begin
            if (rwp[s1_idx[IDX_W-1:0]] && orig[rd_rpc]) begin
              acc_row <= acc_row ^ rd_red;
              acc_ops <= acc_ops ^ rd_ops;
            end
          end
          OP_COL: begin
            if (!found && !rwp[s1_idx[IDX_W-1:0]] && (par || rd_red[col_count[IDX_W-1:0]]))
            begin
              found   <= 1'b1;
              piv_row <= s1_idx;
            end
          end
          OP_LOAD: begin
            acc_row <= rd_red;
            acc_ops <= rd_ops;
          end
          default: ;
        endcase
      end
      if (cmd.scan_en && !found && (chunk_bits != 8'd0)) begin
        found   <= 1'b1;
        piv_col <= {cmd.chunk, low_bit8(chunk_bits)};
      end
      if (cmd.wnew) row_count <= row_count + 1'b1;
      if (cmd.col_inc) col_count <= col_count + 1'b1;
      if (cmd.commit) begin
        cwp         <= cwp | (VEC_W'(1) << piv_col);
        rwp         <= rwp | (VEC_W'(1) << piv_row);
        pivot_count <= pivot_count + 1'b1;
      end
      if (cmd.finish) begin
        rank        <= pivot_count;
        pivot_found <= found;
        rejected    <= cmd.reject;
        if (!found) pivot_index <= '0;
        else if (mode_q == MODE_ROW) pivot_index <= piv_col;
        else pivot_index <= piv_row[IDX_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/gf2_incremental_row_reducer_top.sv =====
// Top level of the GF(2) incremental row reducer.
// Add row: elimination sweep, pivot scan, row write, then a clearing sweep on a new
// pivot. Add column: column sweep, then pivot load and clearing sweep on a new pivot.
// Restart or rejected items go straight to the result; sweeps read one row a cycle.
// Busy falls as the result appears, so the next item can follow straight after;
// the receiver cannot stall. Synchronous reset empties the matrix, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module gf2_incremental_row_reducer_top #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  mode,
  input  wire  [63:0] row_bits,
  input  wire  [63:0] column_bits,
  input  wire  [6:0]  start_cols,
  output logic        done,
  output logic [6:0]  rank,
  output logic        pivot_found,
  output logic [5:0]  pivot_index,
  output logic        rejected
);
  import gir_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gir_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .mode(mode), .start_cols(start_cols),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  gir_datapath #(.MAX_ROWS(MAX_ROWS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .mode(mode), .row_bits(row_bits),
    .column_bits(column_bits), .start_cols(start_cols), .stat(stat), .done(done),
    .rank(rank), .pivot_found(pivot_found), .pivot_index(pivot_index),
    .rejected(rejected)
  );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the GF(2) incremental row reducer top level.
// Predicts each item's result with its own echelon-form model; depends on gir_pkg.
`timescale 1ns / 1ps
module testbench;
  import gir_pkg::*;

  typedef struct {
    logic [1:0]  mode;
    logic [63:0] row_bits;
    logic [63:0] column_bits;
    logic [6:0]  start_cols;
    bit          drain;
  } item_t;

  typedef struct {
    logic [6:0] rank;
    logic       pivot_found;
    logic [5:0] pivot_index;
    logic       rejected;
  } answer_t;

  localparam int LIMIT = 2000000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [6:0] NO_PIVOT = 7'd64;

  logic clk, rst, start, busy, done;
  logic [1:0] mode;
  logic [63:0] row_bits, column_bits;
  logic [6:0] start_cols, rank;
  logic pivot_found, rejected;
  logic [5:0] pivot_index;

  gf2_incremental_row_reducer_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .row_bits(row_bits), .column_bits(column_bits), .start_cols(start_cols),
    .done(done), .rank(rank), .pivot_found(pivot_found),
    .pivot_index(pivot_index), .rejected(rejected)
  );

  logic [63:0] red_rows [64];
  logic [63:0] op_rows [64];
  logic [6:0]  pivot_row_of_col [64];
  logic [63:0] pivot_cols, pivot_rows;
  int unsigned n_rows, n_cols, n_pivots;

  item_t   pending_items[$];
  answer_t expected_answers[$];
  int      sender_idle_pct;
  int      errors = 0;
  int      cycle_count;
  bit      stimulus_done;

  function automatic logic [63:0] mask_below(int unsigned n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic void clear_matrix(int unsigned cols);
    for (int i = 0; i < 64; i++) begin
      red_rows[i] = '0;
      op_rows[i] = '0;
      pivot_row_of_col[i] = NO_PIVOT;
    end
    pivot_cols = '0;
    pivot_rows = '0;
    n_rows = 0;
    n_cols = cols;
    n_pivots = 0;
  endfunction

  function automatic void eliminate_column(int unsigned c, int unsigned p);
    for (int i = 0; i < n_rows; i++) begin
      if (i != p && red_rows[i][c]) begin
        red_rows[i] ^= red_rows[p];
        op_rows[i] ^= op_rows[p];
      end
    end
  endfunction

  function automatic answer_t reduce_item(item_t it);
    answer_t a;
    int unsigned r, c, p;
    logic [63:0] v, ops;
    bit hit;
    a.pivot_found = 1'b0;
    a.pivot_index = '0;
    a.rejected = 1'b0;
    hit = 0;
    case (it.mode)
      MODE_ROW: begin
        if (n_rows >= 64) begin
          a.rejected = 1'b1;
        end else begin
          r = n_rows;
          v = it.row_bits & mask_below(n_cols);
          ops = 64'd1 << r;
          for (int k = 0; k < n_cols; k++) begin
            if (pivot_cols[k] && v[k]) begin
              v ^= red_rows[pivot_row_of_col[k][5:0]];
              ops ^= op_rows[pivot_row_of_col[k][5:0]];
            end
          end
          red_rows[r] = v;
          op_rows[r] = ops;
          n_rows = r + 1;
          for (int k = 0; k < n_cols && !hit; k++) begin
            if (!pivot_cols[k] && v[k]) begin
              hit = 1;
              c = k;
            end
          end
          if (hit) begin
            pivot_cols[c] = 1'b1;
            pivot_rows[r] = 1'b1;
            pivot_row_of_col[c] = 7'(r);
            n_pivots++;
            eliminate_column(c, r);
            a.pivot_found = 1'b1;
            a.pivot_index = 6'(c);
          end
        end
      end
      MODE_COL: begin
        if (n_cols >= 64) begin
          a.rejected = 1'b1;
        end else begin
          c = n_cols;
          v = it.column_bits & mask_below(n_rows);
          for (int i = 0; i < n_rows; i++) begin
            if (^(op_rows[i] & v)) red_rows[i][c] = 1'b1;
          end
          n_cols = c + 1;
          for (int i = 0; i < n_rows && !hit; i++) begin
            if (!pivot_rows[i] && red_rows[i][c]) begin
              hit = 1;
              p = i;
            end
          end
          if (hit) begin
            pivot_rows[p] = 1'b1;
            pivot_cols[c] = 1'b1;
            pivot_row_of_col[c] = 7'(p);
            n_pivots++;
            eliminate_column(c, p);
            a.pivot_found = 1'b1;
            a.pivot_index = 6'(p);
          end
        end
      end
      MODE_RESTART: begin
        if (it.start_cols > 7'd64) a.rejected = 1'b1;
        else clear_matrix(it.start_cols);
      end
      default: a.rejected = 1'b1;
    endcase
    a.rank = 7'(n_pivots);
    return a;
  endfunction

  function automatic logic [63:0] rand_vec();
    logic [63:0] v;
    int sel;
    v = {$urandom(), $urandom()};
    sel = $urandom_range(0, 9);
    if (sel == 0) v = '0;
    else if (sel == 1) v = '1;
    else if (sel <= 4) v &= {$urandom(), $urandom()} & {$urandom(), $urandom()};
    else if (sel == 5) v = 64'd1 << $urandom_range(0, 63);
    return v;
  endfunction

  task automatic push_item(logic [1:0] m, logic [63:0] rb, logic [63:0] cb,
                           logic [6:0] sc);
    item_t it;
    it.mode = m;
    it.row_bits = rb;
    it.column_bits = cb;
    it.start_cols = sc;
    it.drain = 0;
    pending_items = {pending_items, it};
  endtask

  task automatic push_drain();
    item_t it;
    it.mode = MODE_UNUSED;
    it.row_bits = '0;
    it.column_bits = '0;
    it.start_cols = '0;
    it.drain = 1;
    pending_items = {pending_items, it};
  endtask

  // One random session: restart with a column count, then rows, columns and invalid items.
  task automatic push_session(int unsigned len);
    int unsigned sc;
    sc = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(0, 40);
    push_item(MODE_RESTART, rand_vec(), rand_vec(), 7'(sc));
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 19))
        0: push_item(MODE_UNUSED, rand_vec(), rand_vec(), 7'($urandom_range(0, 127)));
        1: push_item(MODE_RESTART, rand_vec(), rand_vec(), 7'($urandom_range(65, 127)));
        2, 3, 4, 5, 6, 7:
          push_item(MODE_COL, rand_vec(), rand_vec(), 7'($urandom_range(0, 127)));
        default:
          push_item(MODE_ROW, rand_vec(), rand_vec(), 7'($urandom_range(0, 127)));
      endcase
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    // Directed part: empty matrix, extremes, unused mode and oversized restart.
    push_item(MODE_ROW, '1, '0, 7'd0);
    push_item(MODE_COL, '0, '1, 7'd0);
    push_item(MODE_UNUSED, '1, '1, 7'h7f);
    push_item(MODE_RESTART, '0, '0, 7'd65);
    push_item(MODE_RESTART, '0, '0, 7'h7f);
    push_item(MODE_RESTART, '0, '0, 7'd64);
    push_item(MODE_ROW, 64'h8000_0000_0000_0000, '0, 7'd0);
    push_item(MODE_ROW, '1, '0, 7'd0);
    push_item(MODE_ROW, '1, '0, 7'd0);
    push_item(MODE_ROW, 64'h5555_5555_5555_5555, '0, 7'd0);
    push_item(MODE_ROW, '0, '0, 7'd0);
    push_item(MODE_COL, '0, '1, 7'd0);
    push_item(MODE_RESTART, '0, '0, 7'd3);
    push_item(MODE_ROW, 64'hffff_ffff_ffff_fff8, '0, 7'd0);
    push_item(MODE_COL, '0, '1, 7'd0);
    push_item(MODE_COL, '0, 64'd2, 7'd0);
    push_item(MODE_COL, '0, '0, 7'd0);
    // Column capacity: 64 columns then one more.
    push_item(MODE_RESTART, '0, '0, 7'd63);
    push_item(MODE_COL, '0, '1, 7'd0);
    push_item(MODE_COL, '0, '1, 7'd0);
    push_item(MODE_RESTART, '0, '0, 7'd0);
    for (int k = 0; k < 66; k++) push_item(MODE_ROW, '1, '0, 7'd0);
    push_item(MODE_COL, '0, 64'h8000_0000_0000_0001, 7'd0);
    push_drain();
    while (pending_items.size() < 760) push_session($urandom_range(4, 60));
    // A full-rank run to reach row capacity with pivots.
    push_item(MODE_RESTART, '0, '0, 7'd64);
    for (int k = 0; k < 66; k++) push_item(MODE_ROW, rand_vec(), '0, 7'd0);
  end

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  int unsigned accepted;
  int unsigned drain_wait;
  item_t cur;
  logic busy_at_edge;

  // Driver: presents items at the falling edge, holds start until accepted.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      mode <= '0;
      row_bits <= '0;
      column_bits <= '0;
      start_cols <= '0;
      accepted <= 0;
      drain_wait <= 0;
      sender_idle_pct <= 29;
      stimulus_done <= 0;
    end else if (start && !busy_at_edge) begin
      accepted <= accepted + 1;
      sender_idle_pct <= (accepted < 300) ? 29 : (accepted < 600) ? 76 : 0;
      start <= 1'b0;
    end else if (!start) begin
      if (pending_items.size() == 0) begin
        stimulus_done <= 1;
      end else if (pending_items[0].drain) begin
        if (expected_answers.size() == 0) begin
          if (drain_wait >= 200) begin
            void'(pending_items.pop_front());
            drain_wait <= 0;
          end else begin
            drain_wait <= drain_wait + 1;
          end
        end
      end else if ($urandom_range(0, 99) >= sender_idle_pct) begin
        cur = pending_items.pop_front();
        mode <= cur.mode;
        row_bits <= cur.row_bits;
        column_bits <= cur.column_bits;
        start_cols <= cur.start_cols;
        start <= 1'b1;
      end
    end
  end

  // Monitor: acceptance of items and results at the rising edge.
  always @(posedge clk) begin
    answer_t got, want;
    item_t seen;
    busy_at_edge <= busy;
    if (rst) begin
      clear_matrix(0);
    end else begin
      if (start && !busy) begin
        seen.mode = mode;
        seen.row_bits = row_bits;
        seen.column_bits = column_bits;
        seen.start_cols = start_cols;
        seen.drain = 1'b0;
        expected_answers = {expected_answers, reduce_item(seen)};
      end
      if (done) begin
        got = '{rank, pivot_found, pivot_index, rejected};
        if (expected_answers.size() == 0) begin
          errors++;
          $display("%0t: unexpected result rank %0d found %0d index %0d rejected %0d",
                   $time, rank, pivot_found, pivot_index, rejected);
        end else begin
          want = expected_answers.pop_front();
          if (got.rank !== want.rank || got.pivot_found !== want.pivot_found ||
              got.pivot_index !== want.pivot_index || got.rejected !== want.rejected) begin
            errors++;
            $display("%0t: expected rank %0d found %0d index %0d rejected %0d,",
                     $time, want.rank, want.pivot_found, want.pivot_index,
                     want.rejected);
            $display("%0t: got rank %0d found %0d index %0d rejected %0d",
                     $time, got.rank, got.pivot_found, got.pivot_index,
                     got.rejected);
          end
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    @(negedge rst);
    while (!(stimulus_done && !start && expected_answers.size() == 0) &&
           cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    if (cycle_count >= LIMIT) begin
      $display("[gf2_incremental_row_reducer_top] ERROR");
    end else begin
      repeat (200) @(posedge clk);
      if (errors == 0 && expected_answers.size() == 0) begin
        $display("[gf2_incremental_row_reducer_top] OK");
      end else begin
        $display("[gf2_incremental_row_reducer_top] ERROR");
      end
    end
    $finish;
  end

endmodule
